// ===== rtl/kkhi_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kkhi_pkg
// Shared constants, codes and controller/datapath interface types for the
// key/kind hash index.
// ---------------------------------------------------------------------------
package kkhi_pkg;

  // Default sizing
  localparam int BUCKETS_DEF      = 1024;
  localparam int POOL_ENTRIES_DEF = 4096;
  localparam int LIMIT_CAP_DEF    = 63;

  // Field widths
  localparam int KEY_W   = 64;
  localparam int KIND_W  = 32;
  localparam int LOC_W   = 64;
  localparam int TIME_W  = 64;
  localparam int LIM_W   = 6;
  localparam int RT_W    = 2;
  localparam int ST_W    = 2;
  localparam int IN_DW   = 552;
  localparam int OUT_DW  = 136;

  // Low word of the golden-ratio multiplier; only low hash bits are used
  localparam logic [31:0] GOLDEN_LO = 32'h7F4A7C15;

  // Operations
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_ITERATE = 1'b1;

  // Result types
  localparam logic [RT_W-1:0] RT_STATUS = 2'd0;
  localparam logic [RT_W-1:0] RT_MATCH  = 2'd1;
  localparam logic [RT_W-1:0] RT_DONE   = 2'd2;

  // Insert status codes
  localparam logic [ST_W-1:0] ST_OK         = 2'd0;
  localparam logic [ST_W-1:0] ST_POOL_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_TABLE_FULL = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic            load;
    logic            clear;
    logic            hash;
    logic            bucket_rd;
    logic            probe_next;
    logic            insert_wr;
    logic            chain_start;
    logic            pool_rd;
    logic            chain_step;
    logic            emit;
    logic [RT_W-1:0] emit_type;
    logic [ST_W-1:0] emit_status;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic op;
    logic clr_last;
    logic pool_full;
    logic used;
    logic hit;
    logic probe_last;
    logic chain_end;
    logic pass;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/kkhi_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kkhi_dp
// Datapath: item registers, hash, bucket and pool memories, chain walker,
// time filter and the result register.
// ---------------------------------------------------------------------------
module kkhi_dp #(
  parameter int BUCKETS      = kkhi_pkg::BUCKETS_DEF,
  parameter int POOL_ENTRIES = kkhi_pkg::POOL_ENTRIES_DEF,
  parameter int LIMIT_CAP    = kkhi_pkg::LIMIT_CAP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kkhi_pkg::cmd_t              cmd,
  output kkhi_pkg::stat_t             stat,
  input  logic [kkhi_pkg::IN_DW-1:0]  in_tdata,
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [kkhi_pkg::OUT_DW-1:0] out_tdata,
  output logic [kkhi_pkg::RT_W-1:0]   out_tuser,
  output logic                        out_tlast
);

  localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int PW  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int PCW = $clog2(POOL_ENTRIES + 1);
  localparam int KW4 = 4 * kkhi_pkg::KEY_W;
  localparam int LW  = kkhi_pkg::LIM_W;

  // Bucket and pool storage
  logic                        used_mem  [BUCKETS];
  logic [KW4-1:0]              key_mem   [BUCKETS];
  logic [kkhi_pkg::KIND_W-1:0] kind_mem  [BUCKETS];
  logic [PW-1:0]               head_mem  [BUCKETS];
  logic [PCW-1:0]              ent_mem   [BUCKETS];
  logic [kkhi_pkg::LOC_W-1:0]  ploc_mem  [POOL_ENTRIES];
  logic [kkhi_pkg::TIME_W-1:0] ptime_mem [POOL_ENTRIES];
  logic [PW-1:0]               polder_mem[POOL_ENTRIES];

  // Item registers
  logic                        op_r;
  logic [KW4-1:0]              key_r;
  logic [kkhi_pkg::KIND_W-1:0] kind_r;
  logic [kkhi_pkg::LOC_W-1:0]  loc_r;
  logic signed [kkhi_pkg::TIME_W-1:0] time_r, from_r, to_r;
  logic [LW-1:0]               limit_r;

  // Probe, chain and allocator state
  logic [BW-1:0]  idx_r, probes_r, clr_r;
  logic [PCW-1:0] next_free_r, left_r;
  logic [PW-1:0]  cur_r;
  logic [LW-1:0]  count_r;

  // Registered memory reads
  logic                        used_q;
  logic [KW4-1:0]              key_q;
  logic [kkhi_pkg::KIND_W-1:0] kind_q;
  logic [PW-1:0]               head_q;
  logic [PCW-1:0]              ent_q;
  logic [kkhi_pkg::LOC_W-1:0]  ploc_q;
  logic signed [kkhi_pkg::TIME_W-1:0] ptime_q;
  logic [PW-1:0]               polder_q;

  // Result register
  logic                        out_valid_r;
  logic [kkhi_pkg::RT_W-1:0]   out_type_r;
  logic [kkhi_pkg::ST_W-1:0]   out_st_r;
  logic [kkhi_pkg::LOC_W-1:0]  out_loc_r;
  logic [kkhi_pkg::TIME_W-1:0] out_time_r;
  logic [LW-1:0]               out_total_r;
  logic                        out_last_r;

  logic [31:0]    prod;
  logic [LW-1:0]  lim_in;
  logic           hit;
  logic           pass;
  logic           out_free;

  assign prod   = kind_r * kkhi_pkg::GOLDEN_LO;
  assign lim_in = in_tdata[549:544];
  assign hit    = used_q && (kind_q == kind_r) && (key_q == key_r);
  assign pass   = !((from_r > 0) && (ptime_q < from_r)) &&
                  !((to_r > 0) && (ptime_q > to_r));
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    stat.op         = op_r;
    stat.clr_last   = (clr_r == BW'(BUCKETS - 1));
    stat.pool_full  = (next_free_r >= PCW'(POOL_ENTRIES));
    stat.used       = used_q;
    stat.hit        = hit;
    stat.probe_last = (probes_r == BW'(BUCKETS - 1));
    stat.chain_end  = (left_r == '0) || (count_r == limit_r);
    stat.pass       = pass;
    stat.out_free   = out_free;
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_tuser;
      key_r   <= in_tdata[255:0];
      kind_r  <= in_tdata[287:256];
      loc_r   <= in_tdata[351:288];
      time_r  <= in_tdata[415:352];
      from_r  <= in_tdata[479:416];
      to_r    <= in_tdata[543:480];
      limit_r <= ((lim_in == '0) || (lim_in > LW'(LIMIT_CAP))) ? LW'(LIMIT_CAP) : lim_in;
    end
  end

  // Probe index and clear sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hash) begin
      idx_r    <= key_r[BW-1:0] ^ prod[BW-1:0];
      probes_r <= '0;
    end else if (cmd.probe_next) begin
      idx_r    <= idx_r + 1'b1;
      probes_r <= probes_r + 1'b1;
    end
  end

  // Bucket used bits: swept clear after reset, set on claim
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      used_mem[clr_r] <= 1'b0;
    end else if (cmd.insert_wr) begin
      used_mem[idx_r] <= 1'b1;
    end
    if (cmd.bucket_rd) begin
      used_q <= used_mem[idx_r];
    end
  end

  // Bucket contents
  always_ff @(posedge clk) begin
    if (cmd.insert_wr) begin
      key_mem[idx_r]  <= key_r;
      kind_mem[idx_r] <= kind_r;
      head_mem[idx_r] <= next_free_r[PW-1:0];
      ent_mem[idx_r]  <= hit ? ent_q + 1'b1 : PCW'(1);
    end
    if (cmd.bucket_rd) begin
      key_q  <= key_mem[idx_r];
      kind_q <= kind_mem[idx_r];
      head_q <= head_mem[idx_r];
      ent_q  <= ent_mem[idx_r];
    end
  end

  // Pool entries
  always_ff @(posedge clk) begin
    if (cmd.insert_wr) begin
      ploc_mem[next_free_r[PW-1:0]]   <= loc_r;
      ptime_mem[next_free_r[PW-1:0]]  <= time_r;
      polder_mem[next_free_r[PW-1:0]] <= head_q;
    end
    if (cmd.pool_rd) begin
      ploc_q   <= ploc_mem[cur_r];
      ptime_q  <= ptime_mem[cur_r];
      polder_q <= polder_mem[cur_r];
    end
  end

  // Bump allocator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r <= '0;
    end else if (cmd.insert_wr) begin
      next_free_r <= next_free_r + 1'b1;
    end
  end

  // Chain walker; zero the count on every new item so an absent key reports 0
  always_ff @(posedge clk) begin
    if (cmd.chain_start) begin
      cur_r   <= head_q;
      left_r  <= ent_q;
      count_r <= '0;
    end else if (cmd.chain_step) begin
      cur_r  <= polder_q;
      left_r <= left_r - 1'b1;
      if (pass) begin
        count_r <= count_r + 1'b1;
      end
    end else if (cmd.hash) begin
      count_r <= '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_type_r  <= cmd.emit_type;
      out_st_r    <= cmd.emit_status;
      out_loc_r   <= (cmd.emit_type == kkhi_pkg::RT_MATCH) ? ploc_q : '0;
      out_time_r  <= (cmd.emit_type == kkhi_pkg::RT_MATCH) ? ptime_q : '0;
      out_total_r <= (cmd.emit_type == kkhi_pkg::RT_DONE) ? count_r : '0;
      out_last_r  <= (cmd.emit_type != kkhi_pkg::RT_MATCH);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_type_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_total_r, out_time_r, out_loc_r, out_st_r};

endmodule

// ===== rtl/kkhi_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kkhi_ctrl
// Controller: sequences the clear sweep, hashing, probing, insert writes,
// chain walk and result transfers.
// ---------------------------------------------------------------------------
module kkhi_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  kkhi_pkg::stat_t stat,
  output kkhi_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HASH   = 4'd2;
  localparam logic [3:0] S_RD     = 4'd3;
  localparam logic [3:0] S_CMP    = 4'd4;
  localparam logic [3:0] S_WR     = 4'd5;
  localparam logic [3:0] S_STATUS = 4'd6;
  localparam logic [3:0] S_LOOP   = 4'd7;
  localparam logic [3:0] S_CHK    = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]                state_r, state_nxt;
  logic [kkhi_pkg::ST_W-1:0] st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      st_r    <= kkhi_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash = 1'b1;
        if (stat.op == kkhi_pkg::OP_INSERT && stat.pool_full) begin
          st_nxt    = kkhi_pkg::ST_POOL_FULL;
          state_nxt = S_STATUS;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.bucket_rd = 1'b1;
        state_nxt     = S_CMP;
      end
      S_CMP: begin
        if (!stat.used || stat.hit) begin
          if (stat.op == kkhi_pkg::OP_INSERT) begin
            state_nxt = S_WR;
          end else if (stat.hit) begin
            cmd.chain_start = 1'b1;
            state_nxt       = S_LOOP;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          cmd.probe_next = 1'b1;
          if (!stat.probe_last) begin
            state_nxt = S_RD;
          end else if (stat.op == kkhi_pkg::OP_INSERT) begin
            st_nxt    = kkhi_pkg::ST_TABLE_FULL;
            state_nxt = S_STATUS;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_WR: begin
        cmd.insert_wr = 1'b1;
        st_nxt        = kkhi_pkg::ST_OK;
        state_nxt     = S_STATUS;
      end
      S_STATUS: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_type   = kkhi_pkg::RT_STATUS;
          cmd.emit_status = st_r;
          state_nxt       = S_IDLE;
        end
      end
      S_LOOP: begin
        if (stat.chain_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.pool_rd = 1'b1;
          state_nxt   = S_CHK;
        end
      end
      S_CHK: begin
        // Hold a passing entry until the result register is free
        if (!stat.pass || stat.out_free) begin
          cmd.chain_step = 1'b1;
          cmd.emit       = stat.pass;
          cmd.emit_type  = kkhi_pkg::RT_MATCH;
          state_nxt      = S_LOOP;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_type = kkhi_pkg::RT_DONE;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/key_kind_hash_index.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// key_kind_hash_index
// Hash index from a 256-bit key and 32-bit kind to a newest-first chain of
// (location, time) entries, with insert and filtered iterate.
// ---------------------------------------------------------------------------
// After reset the block sweeps the bucket table clear and takes no item until
// that is done. One item is worked at a time. An insert is accepted, hashed,
// then probes bucket by bucket, each probe a read and a compare over the
// single-port bucket memory, then writes and hands off its status; an insert
// that finds the pool full skips the probe and hands off its status right
// after the hash. An iterate is accepted, hashed and probed the same way, then
// visits each chain entry through a pool memory read and a check, ends the
// walk and hands off the done result; a stalled output holds the walk. The
// table size BUCKETS must be a power of two. The next item can be taken while
// the last result still waits in the output register.
module key_kind_hash_index #(
  parameter int BUCKETS      = kkhi_pkg::BUCKETS_DEF,
  parameter int POOL_ENTRIES = kkhi_pkg::POOL_ENTRIES_DEF,
  parameter int LIMIT_CAP    = kkhi_pkg::LIMIT_CAP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // key_word_0..3, entry_kind, event_location, event_time, time_from,
  // time_to, max_matches, zero pad
  input  logic [kkhi_pkg::IN_DW-1:0]  in_tdata,
  // operation
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // status, found_location, found_time, match_total
  output logic [kkhi_pkg::OUT_DW-1:0] out_tdata,
  // result_type
  output logic [kkhi_pkg::RT_W-1:0]   out_tuser,
  output logic                        out_tlast
);

  kkhi_pkg::cmd_t  cmd;
  kkhi_pkg::stat_t stat;

  kkhi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kkhi_dp #(
    .BUCKETS      (BUCKETS),
    .POOL_ENTRIES (POOL_ENTRIES),
    .LIMIT_CAP    (LIMIT_CAP)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for key_kind_hash_index: drives inserts and iterates
// over the input stream, predicts results from a local model of the bucket
// table and entry pool (directed rows carry their own), and compares results in order.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int          NBKT        = kkhi_pkg::BUCKETS_DEF;
  localparam int          NPOOL       = kkhi_pkg::POOL_ENTRIES_DEF;
  localparam int          CAP         = kkhi_pkg::LIMIT_CAP_DEF;
  localparam logic [63:0] PHI         = 64'h9E3779B97F4A7C15;
  localparam int          STALL_LIMIT = 30000;
  localparam int          NKEYS       = 8;

  typedef struct {
    logic        op;
    logic [63:0] k0, k1, k2, k3;
    logic [31:0] kind;
    logic [63:0] loc;
    logic [63:0] tm, from, upto;
    logic [5:0]  lim;
  } req_t;

  typedef struct packed {
    logic [1:0]  rt;
    logic [1:0]  st;
    logic [63:0] loc;
    logic [63:0] tm;
    logic [5:0]  total;
    logic        last;
  } res_t;

  typedef struct {
    req_t req;
    bit   typed;
    res_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [kkhi_pkg::IN_DW-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [kkhi_pkg::OUT_DW-1:0] out_tdata;
  logic [kkhi_pkg::RT_W-1:0] out_tuser;
  logic out_tlast;

  // Shadow copy of the index
  bit          shadow_used[NBKT];
  logic [63:0] shadow_key[NBKT][4];
  logic [31:0] shadow_kind[NBKT];
  int          shadow_head[NBKT];
  int          shadow_count[NBKT];
  logic [63:0] entry_loc[NPOOL];
  logic [63:0] entry_time[NPOOL];
  int          entry_older[NPOOL];
  int          alloc_ptr = 0;

  res_t pending_q[$];
  row_t dir_rows[$];
  req_t key_set[NKEYS];
  int   fail_cnt = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   hold_cycles = 0;

  key_kind_hash_index dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic res_t mk_res(logic [1:0] rt, logic [1:0] st, logic [63:0] loc,
                                  logic [63:0] tm, logic [5:0] total, logic last);
    res_t r;
    r.rt = rt; r.st = st; r.loc = loc; r.tm = tm; r.total = total; r.last = last;
    return r;
  endfunction

  function automatic req_t mk_req(logic op, logic [63:0] k0, logic [63:0] k1,
                                  logic [63:0] k2, logic [63:0] k3, logic [31:0] kind,
                                  logic [63:0] loc, logic [63:0] tm, logic [63:0] from,
                                  logic [63:0] upto, logic [5:0] lim);
    req_t r;
    r.op = op; r.k0 = k0; r.k1 = k1; r.k2 = k2; r.k3 = k3; r.kind = kind;
    r.loc = loc; r.tm = tm; r.from = from; r.upto = upto; r.lim = lim;
    return r;
  endfunction

  // Search the table: 1 hit, 0 free bucket reached, -1 table full with no hit
  function automatic int find_bucket(req_t r, output int slot);
    logic [63:0] h;
    int idx;
    h = r.k0 ^ (64'(r.kind) * PHI);
    idx = int'(h[9:0]);
    slot = 0;
    for (int n = 0; n < NBKT; n++) begin
      if (!shadow_used[idx]) begin
        slot = idx;
        return 0;
      end
      if (shadow_kind[idx] == r.kind && shadow_key[idx][0] == r.k0 &&
          shadow_key[idx][1] == r.k1 && shadow_key[idx][2] == r.k2 &&
          shadow_key[idx][3] == r.k3) begin
        slot = idx;
        return 1;
      end
      idx = (idx + 1) % NBKT;
    end
    return -1;
  endfunction

  // Apply one request to the shadow index and queue the results it causes
  function automatic void index_predict(req_t r, bit keep);
    int slot, hit, e, left, limit, emitted;
    longint t, lo, hi;
    if (r.op == kkhi_pkg::OP_INSERT) begin
      if (alloc_ptr >= NPOOL) begin
        if (keep) pending_q.push_back(mk_res(kkhi_pkg::RT_STATUS, kkhi_pkg::ST_POOL_FULL,
                                             0, 0, 0, 1'b1));
        return;
      end
      hit = find_bucket(r, slot);
      if (hit < 0) begin
        if (keep) pending_q.push_back(mk_res(kkhi_pkg::RT_STATUS, kkhi_pkg::ST_TABLE_FULL,
                                             0, 0, 0, 1'b1));
        return;
      end
      if (hit == 0) begin
        shadow_used[slot] = 1'b1;
        shadow_key[slot][0] = r.k0;
        shadow_key[slot][1] = r.k1;
        shadow_key[slot][2] = r.k2;
        shadow_key[slot][3] = r.k3;
        shadow_kind[slot] = r.kind;
        shadow_head[slot] = 0;
        shadow_count[slot] = 0;
      end
      e = alloc_ptr;
      entry_loc[e] = r.loc;
      entry_time[e] = r.tm;
      entry_older[e] = shadow_head[slot];
      shadow_head[slot] = e;
      shadow_count[slot]++;
      alloc_ptr++;
      if (keep) pending_q.push_back(mk_res(kkhi_pkg::RT_STATUS, kkhi_pkg::ST_OK,
                                           0, 0, 0, 1'b1));
    end else begin
      lo = r.from;
      hi = r.upto;
      limit = (r.lim == 0 || r.lim > CAP) ? CAP : int'(r.lim);
      emitted = 0;
      hit = find_bucket(r, slot);
      if (hit == 1) begin
        e = shadow_head[slot];
        left = shadow_count[slot];
        while (left > 0 && emitted < limit) begin
          t = entry_time[e];
          if (!((lo > 0 && t < lo) || (hi > 0 && t > hi))) begin
            if (keep) pending_q.push_back(mk_res(kkhi_pkg::RT_MATCH, kkhi_pkg::ST_OK,
                                                 entry_loc[e], entry_time[e], 0, 1'b0));
            emitted++;
          end
          e = entry_older[e];
          left--;
        end
      end
      if (keep) pending_q.push_back(mk_res(kkhi_pkg::RT_DONE, kkhi_pkg::ST_OK, 0, 0,
                                           6'(emitted), 1'b1));
    end
  endfunction

  // Offer one request, with a random gap first, and predict it once accepted
  task automatic send_req(req_t r);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_tuser  <= r.op;
    in_tdata  <= {2'b00, r.lim, r.upto, r.from, r.tm, r.loc, r.kind,
                  r.k3, r.k2, r.k1, r.k0};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    index_predict(r, 1'b1);
  endtask

  // Offer a request whose expectation is already queued
  task automatic send_req_noexp(req_t r);
    @(negedge clk);
    in_tuser  <= r.op;
    in_tdata  <= {2'b00, r.lim, r.upto, r.from, r.tm, r.loc, r.kind,
                  r.k3, r.k2, r.k1, r.k0};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic req_t rand_req();
    req_t r;
    int pick;
    r = key_set[$urandom_range(NKEYS - 1)];
    // a few requests carry fully random keys as noise
    if ($urandom_range(9) == 0) begin
      r.k0 = rand64(); r.k1 = rand64(); r.k2 = rand64(); r.k3 = rand64();
      r.kind = $urandom();
    end
    r.op  = ($urandom_range(99) < 60) ? kkhi_pkg::OP_INSERT : kkhi_pkg::OP_ITERATE;
    r.loc = rand64();
    pick  = $urandom_range(9);
    r.tm  = (pick == 0) ? rand64() : 64'($signed($urandom_range(200)) - 100);
    pick  = $urandom_range(9);
    r.from = (pick == 0) ? rand64() : (pick < 5) ? 64'd0 : 64'($urandom_range(100));
    pick  = $urandom_range(9);
    r.upto = (pick == 0) ? rand64() : (pick < 5) ? 64'd0 : 64'($urandom_range(100));
    r.lim = 6'($urandom_range(63));
    return r;
  endfunction

  // Receiver ready, with an occasional long hold-off
  always begin
    @(negedge clk);
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    res_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = mk_res(out_tuser, out_tdata[1:0], out_tdata[65:2], out_tdata[129:66],
                   out_tdata[135:130], out_tlast);
      if (pending_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result: type %0d status %0d loc %h time %h total %0d last %0d",
                   got.rt, got.st, got.loc, got.tm, got.total, got.last);
      end else begin
        want = pending_q.pop_front();
        if (want !== got) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("mismatch: exp type %0d status %0d loc %h time %h total %0d last %0d",
                     want.rt, want.st, want.loc, want.tm, want.total, want.last);
            $display("          got type %0d status %0d loc %h time %h total %0d last %0d",
                     got.rt, got.st, got.loc, got.tm, got.total, got.last);
          end
        end
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    int quiet;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    req_t r;
    logic [63:0] ones;
    ones = '1;

    // Key set: two pairs share a bucket, one pair differs only in the top word
    for (int i = 0; i < NKEYS; i++)
      key_set[i] = mk_req(kkhi_pkg::OP_INSERT, rand64(), rand64(), rand64(), rand64(),
                          $urandom(), 0, 0, 0, 0, 0);
    key_set[1].k0 = {key_set[0].k0[63:10] ^ 54'h1, key_set[0].k0[9:0]};
    key_set[1].kind = key_set[0].kind;
    key_set[3] = key_set[2];
    key_set[3].k3 = ~key_set[2].k3;

    // Directed rows
    dir_rows.push_back('{mk_req(kkhi_pkg::OP_ITERATE, 1, 2, 3, 4, 5, 0, 0, 0, 0, 0), 1'b1,
                         mk_res(kkhi_pkg::RT_DONE, kkhi_pkg::ST_OK, 0, 0, 0, 1'b1)});
    dir_rows.push_back('{mk_req(kkhi_pkg::OP_INSERT, ones, ones, ones, ones, '1, ones,
                                64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0), 1'b1,
                         mk_res(kkhi_pkg::RT_STATUS, kkhi_pkg::ST_OK, 0, 0, 0, 1'b1)});
    dir_rows.push_back('{mk_req(kkhi_pkg::OP_INSERT, ones, ones, ones, ones, '1, 0,
                                64'h8000_0000_0000_0000, 0, 0, 0), 1'b1,
                         mk_res(kkhi_pkg::RT_STATUS, kkhi_pkg::ST_OK, 0, 0, 0, 1'b1)});
    dir_rows.push_back('{mk_req(kkhi_pkg::OP_INSERT, ones, ones, ones, ones, '1, 64'h55,
                                0, 0, 0, 0),
                         1'b1, mk_res(kkhi_pkg::RT_STATUS, kkhi_pkg::ST_OK, 0, 0, 0, 1'b1)});
    dir_rows.push_back('{mk_req(kkhi_pkg::OP_INSERT, ones, ones, ones, ones, '1, 64'h66,
                                50, 0, 0, 0),
                         1'b1, mk_res(kkhi_pkg::RT_STATUS, kkhi_pkg::ST_OK, 0, 0, 0, 1'b1)});
    dir_rows.push_back('{mk_req(kkhi_pkg::OP_ITERATE, ones, ones, ones, ones, '1,
                                0, 0, 0, 0, 0),
                         1'b0, mk_res(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(kkhi_pkg::OP_ITERATE, ones, ones, ones, ones, '1,
                                0, 0, 1, 0, 63),
                         1'b0, mk_res(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(kkhi_pkg::OP_ITERATE, ones, ones, ones, ones, '1, 0, 0,
                                64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFB, 5),
                         1'b0, mk_res(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(kkhi_pkg::OP_ITERATE, ones, ones, ones, ones, '1,
                                0, 0, 0, 100, 0),
                         1'b0, mk_res(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(kkhi_pkg::OP_ITERATE, ones, ones, ones, ones, '1, 0, 0,
                                64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 1),
                         1'b0, mk_res(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(kkhi_pkg::OP_ITERATE, ones, ones, ones, ones, '1,
                                0, 0, 0, 0, 1),
                         1'b0, mk_res(0, 0, 0, 0, 0, 0)});
    // Colliding keys: same bucket, then neighbors by probing
    dir_rows.push_back('{mk_req(kkhi_pkg::OP_INSERT, 64'h0, 0, 0, 0, 0, 64'h10, 7, 0, 0, 0),
                         1'b0, mk_res(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(kkhi_pkg::OP_INSERT, 64'h400, 0, 0, 0, 0, 64'h20, 8,
                                0, 0, 0),
                         1'b0, mk_res(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(kkhi_pkg::OP_INSERT, 64'h0, 0, 0, 64'h1, 0, 64'h30, 9,
                                0, 0, 0),
                         1'b0, mk_res(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(kkhi_pkg::OP_ITERATE, 64'h400, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                         1'b0, mk_res(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(kkhi_pkg::OP_ITERATE, 64'h0, 0, 0, 64'h1, 0, 0, 0,
                                0, 0, 0),
                         1'b0, mk_res(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(kkhi_pkg::OP_ITERATE, 64'h800, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                         1'b0, mk_res(0, 0, 0, 0, 0, 0)});

    // Reset, then the block clears its table before taking requests
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        index_predict(dir_rows[i].req, 1'b0);
        pending_q.push_back(dir_rows[i].res);
        idle_pct = 101;
        send_req_noexp(dir_rows[i].req);
      end else begin
        idle_pct = 0;
        send_req(dir_rows[i].req);
      end
    end
    drain();

    // Random part in phases with differing input gaps and output stalls
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 58 : 25) : 0;
      stall_pct = (ph == 2) ? 58 : (ph == 3) ? 25 : 0;
      for (int n = 0; n < 63; n++) begin
        if (ph == 0 && n == 10) hold_cycles = 600;
        r = rand_req();
        if (ph == 0 && n >= 10 && n < 30)
          r.op = (n % 4 == 0) ? kkhi_pkg::OP_ITERATE : kkhi_pkg::OP_INSERT;
        send_req(r);
      end
      // sender waits until all results are back
      drain();
    end

    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
